>>> rtl/core/usd_pkg.sv
`timescale 1ns / 1ps

package usd_pkg;

	// Default depth of the run queue between the front and back parts.
	localparam int QUEUE_DEPTH = 4;

	// One input byte causes at most this many results.
	localparam int MAX_RESULTS = 4;
	localparam int IDX_W       = $clog2(MAX_RESULTS);

	// Byte classification constants.
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_TAG   = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'h1F;
	localparam logic [7:0] LEAD3_MASK = 8'h0F;
	localparam logic [7:0] LEAD4_MASK = 8'h07;

	// Sequence lengths.
	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_1    = 3'd1;
	localparam logic [2:0] LEN_2    = 3'd2;
	localparam logic [2:0] LEN_3    = 3'd3;
	localparam logic [2:0] LEN_4    = 3'd4;

	// One result as it leaves the block, without the end-of-run mark.
	typedef struct packed {
		logic [21:0] code_point;
		logic        is_error;
		logic [2:0]  seq_length;
	} result_t;

	// All results caused by one input byte.
	typedef struct packed {
		logic [2:0]                    count;
		result_t [MAX_RESULTS-1:0]     res;
	} run_t;

	// Error result carrying the negated offending byte.
	function automatic result_t err_result(input logic [7:0] b);
		result_t r;
		r.code_point = 22'd0 - {14'd0, b};
		r.is_error   = 1'b1;
		r.seq_length = LEN_1;
		return r;
	endfunction

	// Good result carrying a code point.
	function automatic result_t ok_result(input logic [20:0] cp, input logic [2:0] len);
		result_t r;
		r.code_point = {1'b0, cp};
		r.is_error   = 1'b0;
		r.seq_length = len;
		return r;
	endfunction

endpackage

>>> rtl/core/usd_front.sv
`timescale 1ns / 1ps

module usd_front import usd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	input  logic [7:0] in_byte,
	input  logic       end_of_stream,
	input  logic       q_full,
	output logic       byte_stall,
	output logic       push,
	output run_t       push_run
);

	// Open sequence state.
	logic [7:0]  held_lead_q;
	logic [2:0]  exp_len_q;
	logic [1:0]  held_cnt_q;
	logic [7:0]  held_cont_q [2];
	logic [20:0] partial_q;

	logic [7:0]  held_lead_n;
	logic [2:0]  exp_len_n;
	logic [1:0]  held_cnt_n;
	logic [20:0] partial_n;
	logic        cont_we;

	logic        accept;
	logic        is_cont;
	logic        fresh;
	logic [20:0] shifted;
	logic [2:0]  n;
	run_t        run;

	// A byte is taken whenever the queue has room for its run.
	assign byte_stall = q_full;
	assign accept     = byte_valid && !q_full;
	assign is_cont    = (in_byte & CONT_MASK) == CONT_TAG;
	assign shifted    = {partial_q[14:0], in_byte[5:0]};

	// Classify the byte against the open sequence and build its run of results.
	always_comb begin
		run         = '0;
		n           = 3'd0;
		fresh       = 1'b1;
		cont_we     = 1'b0;
		held_lead_n = held_lead_q;
		exp_len_n   = exp_len_q;
		held_cnt_n  = held_cnt_q;
		partial_n   = partial_q;

		if (exp_len_q != LEN_NONE) begin
			if (is_cont && ({1'b0, held_cnt_q} + 3'd2 >= exp_len_q)) begin
				// Sequence complete.
				fresh       = 1'b0;
				run.res[0]  = ok_result(shifted, exp_len_q);
				n           = 3'd1;
				held_lead_n = 8'd0;
				exp_len_n   = LEN_NONE;
				held_cnt_n  = 2'd0;
				partial_n   = 21'd0;
			end else if (is_cont && !end_of_stream) begin
				// Hold the continuation byte and wait for more.
				fresh      = 1'b0;
				cont_we    = 1'b1;
				held_cnt_n = held_cnt_q + 2'd1;
				partial_n  = shifted;
			end else begin
				// Broken or cut-off sequence: report the lead and the held bytes.
				run.res[0] = err_result(held_lead_q);
				if (held_cnt_q >= 2'd1) begin
					run.res[1] = err_result(held_cont_q[0]);
				end
				if (held_cnt_q >= 2'd2) begin
					run.res[2] = err_result(held_cont_q[1]);
				end
				n           = 3'd1 + {1'b0, held_cnt_q};
				held_lead_n = 8'd0;
				exp_len_n   = LEN_NONE;
				held_cnt_n  = 2'd0;
				partial_n   = 21'd0;
				if (is_cont) begin
					// Cut off by end of stream: the byte itself is an error too.
					fresh                  = 1'b0;
					run.res[n[IDX_W-1:0]]  = err_result(in_byte);
					n                      = n + 3'd1;
				end
			end
		end

		// Decode the byte on its own.
		if (fresh) begin
			if (in_byte inside {[8'h00:8'h7F]}) begin
				run.res[n[IDX_W-1:0]] = ok_result({13'd0, in_byte}, LEN_1);
				n                     = n + 3'd1;
			end else if (in_byte inside {[8'h80:8'hBF], [8'hF8:8'hFF]} || end_of_stream) begin
				run.res[n[IDX_W-1:0]] = err_result(in_byte);
				n                     = n + 3'd1;
			end else begin
				held_lead_n = in_byte;
				held_cnt_n  = 2'd0;
				if (in_byte inside {[8'hC0:8'hDF]}) begin
					exp_len_n = LEN_2;
					partial_n = {13'd0, in_byte & LEAD2_MASK};
				end else if (in_byte inside {[8'hE0:8'hEF]}) begin
					exp_len_n = LEN_3;
					partial_n = {13'd0, in_byte & LEAD3_MASK};
				end else begin
					exp_len_n = LEN_4;
					partial_n = {13'd0, in_byte & LEAD4_MASK};
				end
			end
		end

		run.count = n;
	end

	assign push     = accept && (n != 3'd0);
	assign push_run = run;

	// Sequence state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_lead_q <= 8'd0;
			exp_len_q   <= LEN_NONE;
			held_cnt_q  <= 2'd0;
			partial_q   <= 21'd0;
		end else if (accept) begin
			held_lead_q <= held_lead_n;
			exp_len_q   <= exp_len_n;
			held_cnt_q  <= held_cnt_n;
			partial_q   <= partial_n;
		end
	end

	// Held continuation bytes.
	always_ff @(posedge clk) begin
		if (accept && cont_we) begin
			held_cont_q[held_cnt_q[0]] <= in_byte;
		end
	end

endmodule

>>> rtl/core/usd_queue.sv
`timescale 1ns / 1ps

module usd_queue import usd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  run_t push_run,
	input  logic pop,
	output logic full,
	output logic empty,
	output run_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	run_t          store_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = count_q == CW'(DEPTH);
	assign empty = count_q == '0;
	assign head  = store_q[rd_ptr_q];

	// Run storage.
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_run;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// A transfer into a full queue or out of an empty one would lose or invent runs.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("run pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("run popped from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

endmodule

>>> rtl/core/usd_back.sv
`timescale 1ns / 1ps

module usd_back import usd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        empty,
	input  run_t        head,
	output logic        pop,
	output logic        cp_valid,
	input  logic        cp_stall,
	output logic [21:0] code_point,
	output logic        is_error,
	output logic [2:0]  seq_length,
	output logic        last_of_run
);

	logic [IDX_W-1:0] idx_q;
	logic             valid_q;
	result_t          res_q;
	logic             last_q;
	logic             load;
	logic             last;
	result_t          cur;

	// Walk the head run one result per transfer.
	assign cur  = head.res[idx_q];
	assign last = ({1'b0, idx_q} + 3'd1) == head.count;
	assign load = !empty && (!valid_q || !cp_stall);
	assign pop  = load && last;

	// Result index within the head run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (load) begin
			idx_q <= last ? '0 : idx_q + 1'b1;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!cp_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= cur;
			last_q <= last;
		end
	end

	assign cp_valid    = valid_q;
	assign code_point  = res_q.code_point;
	assign is_error    = res_q.is_error;
	assign seq_length  = res_q.seq_length;
	assign last_of_run = last_q;

	// The walk index never passes the end of the head run.
	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ({1'b0, idx_q} < head.count))
		else $error("result index beyond head run");

endmodule

>>> rtl/core/utf8_stream_decoder.sv
`timescale 1ns / 1ps

// UTF-8 stream decoder.
// Input channel: byte_valid / byte_stall carry in_byte and end_of_stream, one raw
// byte per transfer. Output channel: cp_valid / cp_stall carry code_point,
// is_error, seq_length and last_of_run, one result per transfer.
// Each byte causes zero to four results; a byte that only extends an open
// sequence causes none. Errors carry the negated offending byte.
// Throughput: one byte per cycle while each byte causes at most one result
// and cp_stall is low. A byte that causes k results occupies the output
// register for k transfers; the run queue (DEPTH runs) absorbs such bursts,
// and byte_stall rises only when it is full.
// A byte's results are written into the run queue on its transfer and then
// loaded into the output register when the output side is free.
// Reset clears the open sequence, the queue and the output valid.
// While cp_stall is high the output holds its result, the queue fills, and
// then byte_stall is raised.
module utf8_stream_decoder import usd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  in_byte,
	input  logic        end_of_stream,
	output logic        cp_valid,
	input  logic        cp_stall,
	output logic [21:0] code_point,
	output logic        is_error,
	output logic [2:0]  seq_length,
	output logic        last_of_run
);

	logic push;
	logic pop;
	logic full;
	logic empty;
	run_t push_run;
	run_t head;

	// Classification and sequence assembly.
	usd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.in_byte       (in_byte),
		.end_of_stream (end_of_stream),
		.q_full        (full),
		.byte_stall    (byte_stall),
		.push          (push),
		.push_run      (push_run)
	);

	// Runs waiting to be drained.
	usd_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_run (push_run),
		.pop      (pop),
		.full     (full),
		.empty    (empty),
		.head     (head)
	);

	// Result drain and output register.
	usd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.head        (head),
		.pop         (pop),
		.cp_valid    (cp_valid),
		.cp_stall    (cp_stall),
		.code_point  (code_point),
		.is_error    (is_error),
		.seq_length  (seq_length),
		.last_of_run (last_of_run)
	);

endmodule
